FILE: hdl/tkr_pkg.sv
// Package for the top-k candidate ranker: controller states, command and
// status bundles, field widths and stream layout constants.
// No dependencies.
package tkr_pkg;

  // Field widths
  localparam int unsigned ID_W     = 16;
  localparam int unsigned RANK_W   = 4;
  localparam int unsigned KCNT_W   = 5;
  localparam int unsigned KEY_W    = 100;
  localparam int unsigned OUT_CAP  = 16;

  // Stream layout
  localparam int unsigned IN_TDATA_W  = 104;
  localparam int unsigned OUT_TDATA_W = 24;

  // Item kinds carried in in_tuser
  localparam logic MODE_OFFER = 1'b0;
  localparam logic MODE_FLUSH = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_WALK,
    ST_EMIT
  } tkr_state_t;

  // Controller to datapath
  typedef struct packed {
    logic load_key;    // capture offer key, pick start slot
    logic rd_prev;     // read slot pos-1 instead of slot pos
    logic shift;       // move read entry down into slot pos, step pos back
    logic place;       // write held key into slot pos
    logic emit_start;  // rewind pos for a flush
    logic emit_beat;   // load output register from slot pos, advance pos
    logic clear;       // empty the list
  } tkr_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic lim_zero;    // effective limit is zero
    logic full;        // list holds limit entries
    logic empty;       // list holds nothing
    logic key_before;  // held key ranks before the read entry
    logic pos_zero;    // walk pointer at head
    logic emit_last;   // pos is the final kept entry
    logic out_free;    // output register can take a beat
  } tkr_status_t;

endpackage

FILE: hdl/tkr_ctrl.sv
// Controller for the top-k candidate ranker: sequences offer checks,
// the insertion walk and flush output. Depends on tkr_pkg.
module tkr_ctrl import tkr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [0:0]  in_tuser,
  input  tkr_status_t sts,
  output tkr_cmd_t    cmd
);

  tkr_state_t state_r, state_nxt;

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (in_tuser[0] == MODE_FLUSH) begin
            if (!sts.empty) begin
              cmd.emit_start = 1'b1;
              state_nxt      = ST_EMIT;
            end
          end else if (!sts.lim_zero) begin
            cmd.load_key = 1'b1;
            state_nxt    = sts.full ? ST_CHECK : ST_WALK;
          end
        end
      end
      ST_CHECK: begin
        // full list: new key must beat the last entry
        state_nxt = sts.key_before ? ST_WALK : ST_IDLE;
      end
      ST_WALK: begin
        cmd.rd_prev = 1'b1;
        if (!sts.pos_zero && sts.key_before) begin
          cmd.shift = 1'b1;
        end else begin
          cmd.place = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit_beat = 1'b1;
          if (sts.emit_last) begin
            cmd.clear = 1'b1;
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: hdl/tkr_dpath.sv
// Datapath for the top-k candidate ranker: sorted entry registers, walk
// pointer, fill count, limit register and output register. Depends on tkr_pkg.
module tkr_dpath import tkr_pkg::*; #(
  parameter int unsigned KEEP_MAX = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [KCNT_W-1:0]      cfg_data,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tlast,
  input  tkr_cmd_t               cmd,
  output tkr_status_t            sts
);

  localparam int unsigned DEPTH = (KEEP_MAX < OUT_CAP) ? KEEP_MAX : OUT_CAP;
  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [KEY_W-1:0]  entry_r [DEPTH];
  logic [KEY_W-1:0]  key_r;
  logic [IDX_W-1:0]  pos_r;
  logic [CNT_W-1:0]  kept_r;
  logic [KCNT_W-1:0] keep_count_r;
  logic              out_valid_r;
  logic [ID_W-1:0]   out_vertex_r;
  logic [RANK_W-1:0] out_rank_r;
  logic              out_last_r;

  logic [KCNT_W-1:0] lim_wide;
  logic [CNT_W-1:0]  lim;
  logic [KCNT_W-1:0] cfg_lim_wide;
  logic [CNT_W-1:0]  cfg_lim;
  logic [IDX_W-1:0]  rd_idx;
  logic [KEY_W-1:0]  rd_data;
  logic [KEY_W-1:0]  in_key;

  // Effective limit: keep_count capped at the list depth
  always_comb begin
    lim_wide     = (keep_count_r > KCNT_W'(DEPTH)) ? KCNT_W'(DEPTH) : keep_count_r;
    lim          = CNT_W'(lim_wide);
    cfg_lim_wide = (cfg_data > KCNT_W'(DEPTH)) ? KCNT_W'(DEPTH) : cfg_data;
    cfg_lim      = CNT_W'(cfg_lim_wide);
  end

  // Pack offer keys so that a smaller value ranks better
  assign in_key = {in_tdata[15:0], in_tdata[31:16], in_tdata[51:32],
                   ~in_tdata[67:52], ~in_tdata[83:68], in_tdata[99:84]};

  // Single read port into the entry array
  assign rd_idx  = cmd.rd_prev ? (pos_r - 1'b1) : pos_r;
  assign rd_data = entry_r[rd_idx];

  // Status back to the controller
  always_comb begin
    sts.lim_zero   = (lim == '0);
    sts.full       = (kept_r == lim);
    sts.empty      = (kept_r == '0);
    sts.key_before = (key_r < rd_data);
    sts.pos_zero   = (pos_r == '0);
    sts.emit_last  = ((CNT_W'(pos_r) + 1'b1) == kept_r);
    sts.out_free   = !out_valid_r || out_tready;
  end

  assign cfg_ready = 1'b1;

  // Limit register and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keep_count_r <= KCNT_W'(8);
      kept_r       <= '0;
    end else begin
      if (cfg_valid) begin
        keep_count_r <= cfg_data;
        // cut the list at once when the limit drops
        if (kept_r > cfg_lim) begin
          kept_r <= cfg_lim;
        end
      end else if (cmd.clear) begin
        kept_r <= '0;
      end else if (cmd.load_key && (kept_r != lim)) begin
        kept_r <= kept_r + 1'b1;
      end
    end
  end

  // Held key, walk pointer and entries
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (cmd.load_key) begin
      pos_r <= (kept_r != lim) ? IDX_W'(kept_r) : IDX_W'(kept_r - 1'b1);
    end else if (cmd.shift) begin
      pos_r <= pos_r - 1'b1;
    end else if (cmd.emit_start) begin
      pos_r <= '0;
    end else if (cmd.emit_beat) begin
      pos_r <= pos_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_key) begin
      key_r <= in_key;
    end
    if (cmd.shift) begin
      entry_r[pos_r] <= rd_data;
    end else if (cmd.place) begin
      entry_r[pos_r] <= key_r;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_beat) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_beat) begin
      out_vertex_r <= rd_data[ID_W-1:0];
      out_rank_r   <= RANK_W'(pos_r);
      out_last_r   <= sts.emit_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0, out_rank_r, out_vertex_r};
  assign out_tlast  = out_last_r;

endmodule

FILE: hdl/top_k_candidate_ranker.sv
// Top level of the top-k candidate ranker: joins controller and datapath.
// Depends on tkr_pkg, tkr_ctrl and tkr_dpath.
//
//  channel | direction | beat carries
//  --------+-----------+-------------------------------------------------
//  in_     | sink      | offer keys in tdata, mode in tuser
//  out_    | source    | vertex and rank in tdata, end of flush in tlast
//  cfg_    | sink      | keep_count write
//
// An offer is dropped at a zero limit. Otherwise, when the list is full,
// the new key is first compared against the last entry; it then walks
// up past each entry it ranks before, one entry per step through the
// single-read-port entry array. A flush emits one beat per kept entry
// and is slower only when out_tready is held low.
// Synchronous active-low reset empties the list and sets keep_count to 8.
// Input is taken only while no item is in progress; a stalled output holds.
module top_k_candidate_ranker import tkr_pkg::*; #(
  parameter int unsigned KEEP_MAX = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [15:0] max_comp, [31:16] remaining_vertices,
  // [51:32] edges_left, [67:52] eliminated_vertices,
  // [83:68] orig_degree, [99:84] vertex_id, [103:100] zero
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // [0] mode
  input  logic [0:0]             in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [15:0] out_vertex, [19:16] out_rank, [23:20] zero
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tlast,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [KCNT_W-1:0]      cfg_data
);

  tkr_cmd_t    cmd;
  tkr_status_t sts;

  tkr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .sts       (sts),
    .cmd       (cmd)
  );

  tkr_dpath #(
    .KEEP_MAX (KEEP_MAX)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule

FILE: sim/top_k_candidate_ranker_test.sv
// Self-checking testbench for top_k_candidate_ranker: drives offer and flush
// beats and keep_count writes, predicts every flushed entry and checks it.
// Depends on tkr_pkg and the RTL of the ranker.
module top_k_candidate_ranker_test import tkr_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned KEEP_LIMIT    = 16;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned KEY_BITS      = 100;

  // Offer keys, first field in the lowest bits as on in_tdata
  typedef struct packed {
    logic [15:0] vertex_id;
    logic [15:0] orig_degree;
    logic [15:0] eliminated_vertices;
    logic [19:0] edges_left;
    logic [15:0] remaining_vertices;
    logic [15:0] max_comp;
  } candidate_t;

  typedef struct {
    logic [ID_W-1:0]   vertex;
    logic [RANK_W-1:0] rank;
    logic              last;
  } flush_beat_t;

  // Sorted list of kept candidates and the flush beats still owed
  class ranked_list_model;
    logic [51:0]       kept_primary[KEEP_LIMIT];
    logic [47:0]       kept_tiebreak[KEEP_LIMIT];
    int unsigned       kept_n;
    logic [KCNT_W-1:0] keep_reg;
    flush_beat_t       owed_beats[$];
    int unsigned       mismatches;

    function new();
      kept_n     = 0;
      keep_reg   = 5'd8;
      mismatches = 0;
    endfunction

    function int unsigned active_limit();
      int unsigned lim;
      lim = keep_reg;
      if (lim > KEEP_LIMIT) lim = KEEP_LIMIT;
      if (lim > OUT_CAP) lim = OUT_CAP;
      return lim;
    endfunction

    function bit ranks_ahead(logic [51:0] pa, logic [47:0] ta, logic [51:0] pb,
                             logic [47:0] tb);
      if (pa != pb) return pa < pb;
      return ta < tb;
    endfunction

    // Take a new keep_count; cut the list at once if it shrank
    function void set_keep(logic [KCNT_W-1:0] value);
      keep_reg = value;
      if (kept_n > active_limit()) kept_n = active_limit();
    endfunction

    function void note_item(logic mode, candidate_t cand);
      int unsigned lim;
      int unsigned pos;
      logic [51:0] pk;
      logic [47:0] tk;
      logic [51:0] sp;
      logic [47:0] st;
      flush_beat_t beat;
      lim = active_limit();
      if (mode == MODE_FLUSH) begin
        for (int unsigned i = 0; i < kept_n; i++) begin
          beat.vertex = kept_tiebreak[i][15:0];
          beat.rank   = i[RANK_W-1:0];
          beat.last   = (i + 1 == kept_n);
          owed_beats.push_back(beat);
        end
        kept_n = 0;
        return;
      end
      if (lim == 0) return;
      pk = {cand.max_comp, cand.remaining_vertices, cand.edges_left};
      tk = {~cand.eliminated_vertices, ~cand.orig_degree, cand.vertex_id};
      if (kept_n < lim) begin
        pos = kept_n;
        kept_n++;
      end else begin
        pos = kept_n - 1;
        if (!ranks_ahead(pk, tk, kept_primary[pos], kept_tiebreak[pos])) return;
      end
      kept_primary[pos]  = pk;
      kept_tiebreak[pos] = tk;
      // bubble the new entry up past every entry it strictly beats
      while (pos > 0 && ranks_ahead(kept_primary[pos], kept_tiebreak[pos],
                                    kept_primary[pos-1], kept_tiebreak[pos-1])) begin
        sp = kept_primary[pos-1];
        st = kept_tiebreak[pos-1];
        kept_primary[pos-1]  = kept_primary[pos];
        kept_tiebreak[pos-1] = kept_tiebreak[pos];
        kept_primary[pos]    = sp;
        kept_tiebreak[pos]   = st;
        pos--;
      end
    endfunction

    function void check_beat(logic [ID_W-1:0] vertex, logic [RANK_W-1:0] rank,
                             logic last);
      flush_beat_t due;
      if (owed_beats.size() == 0) begin
        $error("result beat with none owed: out_vertex %0d out_rank %0d out_last %0b",
               vertex, rank, last);
        mismatches++;
        return;
      end
      due = owed_beats.pop_front();
      if (vertex !== due.vertex) begin
        $error("out_vertex: expected %0d, actual %0d", due.vertex, vertex);
        mismatches++;
      end
      if (rank !== due.rank) begin
        $error("out_rank: expected %0d, actual %0d", due.rank, rank);
        mismatches++;
      end
      if (last !== due.last) begin
        $error("out_last: expected %0b, actual %0b", due.last, last);
        mismatches++;
      end
    endfunction

    function int unsigned beats_owed();
      return owed_beats.size();
    endfunction
  endclass

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [0:0]             in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [KCNT_W-1:0]      cfg_data;

  ranked_list_model ranker;

  top_k_candidate_ranker #(
    .KEEP_MAX(KEEP_LIMIT)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Gap length: mostly none, some short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Key value of a given width: tie-prone, full range, mixed or near the top
  function automatic logic [19:0] pick_key(int unsigned spread, int unsigned width);
    logic [19:0] mask;
    mask = (20'h1 << width) - 20'h1;
    if (width == 20) mask = 20'hFFFFF;
    case (spread)
      0: return 20'($urandom_range(0, 3));
      1: return 20'($urandom() & mask);
      2: return ($urandom_range(0, 1) != 0) ? 20'($urandom() & mask)
                                            : 20'($urandom_range(0, 2));
      default: return 20'(mask - $urandom_range(0, 3));
    endcase
  endfunction

  function automatic candidate_t random_candidate();
    candidate_t  cand;
    int unsigned spread;
    spread = $urandom_range(0, 3);
    cand.max_comp            = 16'(pick_key(spread, 16));
    cand.remaining_vertices  = 16'(pick_key(spread, 16));
    cand.edges_left          = pick_key(spread, 20);
    cand.eliminated_vertices = 16'(pick_key(spread, 16));
    cand.orig_degree         = 16'(pick_key(spread, 16));
    cand.vertex_id           = 16'(pick_key(spread, 16));
    return cand;
  endfunction

  function automatic candidate_t make_cand(logic [15:0] lc, logic [15:0] rv,
                                           logic [19:0] re, logic [15:0] el,
                                           logic [15:0] dg, logic [15:0] id);
    candidate_t cand;
    cand.max_comp            = lc;
    cand.remaining_vertices  = rv;
    cand.edges_left          = re;
    cand.eliminated_vertices = el;
    cand.orig_degree         = dg;
    cand.vertex_id           = id;
    return cand;
  endfunction

  // Present one beat on in_, hold it until taken; returns at a falling edge
  task automatic send_item(input logic mode, input candidate_t cand);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {{(IN_TDATA_W-KEY_BITS){1'b0}}, cand};
    do @(posedge clk); while (!in_tready);
    ranker.note_item(mode, cand);
    @(negedge clk);
  endtask

  // Drain owed beats and let any offer still walking the list finish
  task automatic settle_list();
    in_tvalid <= 1'b0;
    while (ranker.beats_owed() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_keep(input logic [KCNT_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    ranker.set_keep(value);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Check every result beat taken
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      ranker.check_beat(out_tdata[15:0], out_tdata[19:16], out_tlast);
    end
  end

  // Stall the result side: calm stretches mixed with short and long holds
  initial begin : drive_out_ready
    int unsigned calm_left;
    int unsigned stall_left;
    calm_left  = 0;
    stall_left = 0;
    out_tready = 1'b1;
    forever begin
      @(negedge clk);
      if (stall_left != 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else if (calm_left != 0) begin
        out_tready <= 1'b1;
        calm_left--;
      end else begin
        out_tready <= 1'b1;
        if ($urandom_range(0, 5) == 0) calm_left = $urandom_range(10, 60);
        else stall_left = pick_gap();
      end
    end
  end

  initial begin
    #3_000_000;
    $display("top_k_candidate_ranker_test: FAIL");
    $finish;
  end

  initial begin : run_stimulus
    candidate_t        base;
    candidate_t        zero_cand;
    candidate_t        max_cand;
    logic [KCNT_W-1:0] phase_keep[7];
    int unsigned       phase_items[7];

    phase_keep  = '{5'd31, 5'd1, 5'd17, 5'd16, 5'd0, 5'd3, 5'd8};
    phase_items = '{25, 10, 20, 25, 4, 10, 25};
    phase_keep[6] = 5'($urandom_range(0, 31));

    ranker    = new();
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = MODE_OFFER;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    base      = make_cand(16'd100, 16'd200, 20'd300, 16'd50, 16'd40, 16'd1000);
    zero_cand = make_cand(16'h0, 16'h0, 20'h0, 16'h0, 16'h0, 16'h0);
    max_cand  = make_cand(16'hFFFF, 16'hFFFF, 20'hFFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);

    // Empty flush, then fill the default list of 8 with extremes and
    // candidates that each win on exactly one key
    send_item(MODE_FLUSH, base);
    send_item(MODE_OFFER, zero_cand);
    send_item(MODE_OFFER, max_cand);
    send_item(MODE_OFFER, base);
    send_item(MODE_OFFER, make_cand(16'd99, 16'd200, 20'd300, 16'd50, 16'd40, 16'd1000));
    send_item(MODE_OFFER, make_cand(16'd100, 16'd199, 20'd300, 16'd50, 16'd40, 16'd1000));
    send_item(MODE_OFFER, make_cand(16'd100, 16'd200, 20'd299, 16'd50, 16'd40, 16'd1000));
    send_item(MODE_OFFER, make_cand(16'd100, 16'd200, 20'd300, 16'd51, 16'd40, 16'd1000));
    send_item(MODE_OFFER, make_cand(16'd100, 16'd200, 20'd300, 16'd50, 16'd41, 16'd1000));
    // Full list: a better one pushes out the worst, equal and worse ones drop
    send_item(MODE_OFFER, make_cand(16'd100, 16'd200, 20'd300, 16'd50, 16'd40, 16'd999));
    send_item(MODE_OFFER, base);
    send_item(MODE_OFFER, max_cand);
    send_item(MODE_FLUSH, zero_cand);
    // Equal entries keep arrival order
    send_item(MODE_OFFER, base);
    send_item(MODE_OFFER, base);
    send_item(MODE_OFFER, make_cand(16'd101, 16'd0, 20'd0, 16'hFFFF, 16'hFFFF, 16'd7));
    send_item(MODE_FLUSH, max_cand);

    // Zero limit keeps nothing
    settle_list();
    write_keep(5'd0);
    send_item(MODE_OFFER, zero_cand);
    send_item(MODE_FLUSH, zero_cand);

    // Lower the limit under a populated list: worst entries drop at once
    settle_list();
    write_keep(5'd16);
    repeat (5) send_item(MODE_OFFER, random_candidate());
    settle_list();
    write_keep(5'd2);
    send_item(MODE_FLUSH, random_candidate());

    // Random phases over several limits, lists left populated across writes
    foreach (phase_keep[p]) begin
      settle_list();
      write_keep(phase_keep[p]);
      repeat (phase_items[p]) begin
        if ($urandom_range(0, 7) == 0) send_item(MODE_FLUSH, random_candidate());
        else send_item(MODE_OFFER, random_candidate());
      end
    end
    send_item(MODE_FLUSH, random_candidate());
    in_tvalid <= 1'b0;

    while (ranker.beats_owed() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (ranker.mismatches == 0) begin
      $display("top_k_candidate_ranker_test: PASS");
    end else begin
      $display("top_k_candidate_ranker_test: FAIL");
    end
    $finish;
  end

endmodule
